FILE: hw/rtl/wscb_pkg.sv
// shared types and constants for the weighted sliding column blur
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package wscb_pkg;
    localparam int COLOR_W = 8;
    localparam int GAIN_W = 10;
    localparam int NUM_W = 10;
    localparam int DIV_W = 11;
    localparam logic [DIV_W-1:0] DIV_RESET = 11'd128;
    localparam int WINDOW_DEFAULT = 96;
    localparam int MAX_GAIN = 766;
    localparam int MAX_COLOR = 255;

    // one classified pixel request, gain already computed
    typedef struct packed {
        logic [COLOR_W-1:0] r;
        logic [COLOR_W-1:0] g;
        logic [COLOR_W-1:0] b;
        logic [GAIN_W-1:0]  gain;
        logic               col_start;
    } item_t;
endpackage
`default_nettype wire

FILE: hw/rtl/weighted_sliding_column_blur.sv
// weighted sliding column blur: front gain unit, two-entry request queue, back end
// the front computes each gain with a bit-serial divider and takes no new pixel until the queue
// accepts the finished request; fill requests pass the back end without a result, while producing
// requests go through the store read and the 8-step quotient unit before the result register
// reset: asynchronous active low; divisor to 128, sums cleared, gain total 1, result register empty
// depends on wscb_pkg, wscb_front, wscb_queue, wscb_back
`timescale 1ns / 1ps
`default_nettype none
module weighted_sliding_column_blur #(
    parameter int WINDOW = wscb_pkg::WINDOW_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    output      logic                          full,
    input  wire logic [wscb_pkg::COLOR_W-1:0]  red_in,
    input  wire logic [wscb_pkg::COLOR_W-1:0]  green_in,
    input  wire logic [wscb_pkg::COLOR_W-1:0]  blue_in,
    input  wire logic                          column_start,
    input  wire logic                          gain_divisor_we,
    input  wire logic [wscb_pkg::DIV_W-1:0]    gain_divisor,
    output      logic                          empty,
    input  wire logic                          pop,
    output      logic [wscb_pkg::COLOR_W-1:0]  red_out,
    output      logic [wscb_pkg::COLOR_W-1:0]  green_out,
    output      logic [wscb_pkg::COLOR_W-1:0]  blue_out
);
    logic            f_valid, f_ready, b_valid, b_pop;
    wscb_pkg::item_t f_item, b_item;

    // front end
    wscb_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .red_in       (red_in),
        .green_in     (green_in),
        .blue_in      (blue_in),
        .column_start (column_start),
        .div_we       (gain_divisor_we),
        .div_wdata    (gain_divisor),
        .item_valid   (f_valid),
        .item_ready   (f_ready),
        .item         (f_item)
    );

    // decoupling queue
    wscb_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_item   (f_item),
        .out_valid (b_valid),
        .out_ready (b_pop),
        .out_item  (b_item)
    );

    // back end
    wscb_back #(
        .WINDOW (WINDOW)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (b_valid),
        .item_pop   (b_pop),
        .item       (b_item),
        .empty      (empty),
        .pop        (pop),
        .red_out    (red_out),
        .green_out  (green_out),
        .blue_out   (blue_out)
    );
endmodule
`default_nettype wire

FILE: hw/rtl/wscb_ram.sv
// generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module wscb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

FILE: hw/rtl/wscb_front.sv
// front end: accepts pixels, holds the divisor register, computes gain bit-serially
// depends on wscb_pkg
`timescale 1ns / 1ps
`default_nettype none
module wscb_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    output      logic                          full,
    input  wire logic [wscb_pkg::COLOR_W-1:0]  red_in,
    input  wire logic [wscb_pkg::COLOR_W-1:0]  green_in,
    input  wire logic [wscb_pkg::COLOR_W-1:0]  blue_in,
    input  wire logic                          column_start,
    input  wire logic                          div_we,
    input  wire logic [wscb_pkg::DIV_W-1:0]    div_wdata,
    output      logic                          item_valid,
    input  wire logic                          item_ready,
    output      wscb_pkg::item_t               item
);
    logic                         busy_reg;
    logic                         done_reg;
    logic [wscb_pkg::DIV_W-1:0]   div_reg;
    logic [wscb_pkg::COLOR_W-1:0] r_reg, g_reg, b_reg;
    logic                         cs_reg;
    logic [wscb_pkg::NUM_W-1:0]   num_reg;
    logic [wscb_pkg::DIV_W:0]     rem_reg;
    logic [wscb_pkg::GAIN_W-1:0]  quo_reg;
    logic [3:0]                   cnt_reg;

    logic [wscb_pkg::DIV_W-1:0]   div_eff;
    logic [wscb_pkg::DIV_W:0]     rem_sh;
    logic                         ge;
    logic [wscb_pkg::DIV_W:0]     rem_next;
    logic [wscb_pkg::NUM_W-1:0]   num_next;

    // restoring divide step of r+g+b by the divisor, zero treated as one
    always_comb
    begin
        div_eff  = (div_reg == '0) ? wscb_pkg::DIV_W'(1) : div_reg;
        rem_sh   = {rem_reg[wscb_pkg::DIV_W-1:0], num_reg[wscb_pkg::NUM_W-1]};
        ge       = rem_sh >= {1'b0, div_eff};
        rem_next = ge ? (rem_sh - {1'b0, div_eff}) : rem_sh;
        num_next = wscb_pkg::NUM_W'(red_in) + wscb_pkg::NUM_W'(green_in)
                 + wscb_pkg::NUM_W'(blue_in);
    end

    assign full       = busy_reg;
    assign item_valid = done_reg;
    assign item.r         = r_reg;
    assign item.g         = g_reg;
    assign item.b         = b_reg;
    assign item.gain      = quo_reg + wscb_pkg::GAIN_W'(1);
    assign item.col_start = cs_reg;

    // control and divisor register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            div_reg  <= wscb_pkg::DIV_RESET;
            cnt_reg  <= '0;
        end
        else
        begin
            if (div_we)
            begin
                div_reg <= div_wdata;
            end
            if (!busy_reg)
            begin
                if (push)
                begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= 4'(wscb_pkg::NUM_W - 1);
                end
            end
            else if (!done_reg)
            begin
                if (cnt_reg == '0)
                begin
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 4'd1;
                end
            end
            else if (item_ready)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b0;
            end
        end
    end

    // pixel capture and divider datapath
    always_ff @(posedge clk)
    begin
        if (!busy_reg && push)
        begin
            r_reg   <= red_in;
            g_reg   <= green_in;
            b_reg   <= blue_in;
            cs_reg  <= column_start;
            num_reg <= num_next;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg && !done_reg)
        begin
            num_reg <= {num_reg[wscb_pkg::NUM_W-2:0], 1'b0};
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[wscb_pkg::GAIN_W-2:0], ge};
        end
    end
endmodule
`default_nettype wire

FILE: hw/rtl/wscb_queue.sv
// two-entry queue between front and back ends
// depends on wscb_pkg
`timescale 1ns / 1ps
`default_nettype none
module wscb_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output      logic            in_ready,
    input  wire wscb_pkg::item_t in_item,
    output      logic            out_valid,
    input  wire logic            out_ready,
    output      wscb_pkg::item_t out_item
);
    wscb_pkg::item_t slot_reg [2];
    logic [1:0] count_reg;
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic       do_push, do_pop;

    assign in_ready  = count_reg != 2'd2;
    assign out_valid = count_reg != 2'd0;
    assign out_item  = slot_reg[rd_ptr_reg];
    assign do_push   = in_valid && in_ready;
    assign do_pop    = out_valid && out_ready;

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end
endmodule
`default_nettype wire

FILE: hw/rtl/wscb_back.sv
// back end: window store, running sums, shared quotient unit and result register
// depends on wscb_pkg and wscb_ram
`timescale 1ns / 1ps
`default_nettype none
module wscb_back #(
    parameter int WINDOW = wscb_pkg::WINDOW_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          item_valid,
    output      logic                          item_pop,
    input  wire wscb_pkg::item_t               item,
    output      logic                          empty,
    input  wire logic                          pop,
    output      logic [wscb_pkg::COLOR_W-1:0]  red_out,
    output      logic [wscb_pkg::COLOR_W-1:0]  green_out,
    output      logic [wscb_pkg::COLOR_W-1:0]  blue_out
);
    localparam int ADDR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int FILL_W = $clog2(WINDOW + 1);
    localparam int SUM_W  = $clog2(WINDOW * wscb_pkg::MAX_COLOR * wscb_pkg::MAX_GAIN + 1);
    localparam int GT_W   = $clog2(WINDOW * wscb_pkg::MAX_GAIN + 2);
    localparam int QW     = wscb_pkg::COLOR_W;
    localparam int DV_W   = GT_W + QW - 1;
    localparam int CMP_W  = SUM_W + DV_W;
    localparam int ENT_W  = 3 * wscb_pkg::COLOR_W + wscb_pkg::GAIN_W;
    localparam int PROD_W = wscb_pkg::COLOR_W + wscb_pkg::GAIN_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_OUT  = 3'd3;

    logic [2:0]        state_reg;
    logic [FILL_W-1:0] fill_reg;
    logic [ADDR_W-1:0] ptr_reg;
    logic [SUM_W-1:0]  rs_reg, gs_reg, bs_reg;
    logic [GT_W-1:0]   gt_reg;
    wscb_pkg::item_t   cur_reg;
    logic [SUM_W-1:0]  rr_reg, gr_reg, br_reg;
    logic [DV_W-1:0]   dv_reg;
    logic [QW-1:0]     rq_reg, gq_reg, bq_reg;
    logic [2:0]        cnt_reg;
    logic              ov_reg;
    logic [QW-1:0]     ro_reg, go_reg, bo_reg;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ENT_W-1:0]  ram_wdata;
    logic [ENT_W-1:0]  ram_rdata;
    logic [FILL_W-1:0] fill_eff;
    logic [ADDR_W-1:0] ptr_eff;
    logic [SUM_W-1:0]  rs_base, gs_base, bs_base;
    logic [GT_W-1:0]   gt_base;
    logic [SUM_W-1:0]  rp_new, gp_new, bp_new, rp_old, gp_old, bp_old;
    logic [SUM_W-1:0]  rs_next, gs_next, bs_next;
    logic [GT_W-1:0]   gt_next;
    logic [wscb_pkg::COLOR_W-1:0] o_r, o_g, o_b;
    logic [wscb_pkg::GAIN_W-1:0]  o_gain;
    logic              r_ge, g_ge, b_ge;
    logic              out_free;

    wscb_ram #(
        .WIDTH (ENT_W),
        .DEPTH (WINDOW)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ptr_eff),
        .rdata (ram_rdata)
    );

    assign o_r    = ram_rdata[ENT_W-1 -: wscb_pkg::COLOR_W];
    assign o_g    = ram_rdata[ENT_W-1-wscb_pkg::COLOR_W -: wscb_pkg::COLOR_W];
    assign o_b    = ram_rdata[wscb_pkg::GAIN_W +: wscb_pkg::COLOR_W];
    assign o_gain = ram_rdata[wscb_pkg::GAIN_W-1:0];

    assign out_free = !ov_reg || pop;
    assign empty    = !ov_reg;
    assign red_out  = ro_reg;
    assign green_out = go_reg;
    assign blue_out = bo_reg;

    // column start clears the fill count, pointer and sums and sets the gain total to one before the pixel is taken
    always_comb
    begin
        if (item.col_start)
        begin
            fill_eff = '0;
            ptr_eff  = '0;
            rs_base  = '0;
            gs_base  = '0;
            bs_base  = '0;
            gt_base  = GT_W'(1);
        end
        else
        begin
            fill_eff = fill_reg;
            ptr_eff  = ptr_reg;
            rs_base  = rs_reg;
            gs_base  = gs_reg;
            bs_base  = bs_reg;
            gt_base  = gt_reg;
        end
    end

    // new and leaving products, sum update
    always_comb
    begin
        logic [wscb_pkg::COLOR_W-1:0] nr, ng, nb;
        logic [wscb_pkg::GAIN_W-1:0]  ngain;
        if (state_reg == S_READ)
        begin
            nr = cur_reg.r; ng = cur_reg.g; nb = cur_reg.b; ngain = cur_reg.gain;
        end
        else
        begin
            nr = item.r; ng = item.g; nb = item.b; ngain = item.gain;
        end
        rp_new = SUM_W'(PROD_W'(nr) * PROD_W'(ngain));
        gp_new = SUM_W'(PROD_W'(ng) * PROD_W'(ngain));
        bp_new = SUM_W'(PROD_W'(nb) * PROD_W'(ngain));
        rp_old = SUM_W'(PROD_W'(o_r) * PROD_W'(o_gain));
        gp_old = SUM_W'(PROD_W'(o_g) * PROD_W'(o_gain));
        bp_old = SUM_W'(PROD_W'(o_b) * PROD_W'(o_gain));
        if (state_reg == S_READ)
        begin
            rs_next = rs_reg - rp_old + rp_new;
            gs_next = gs_reg - gp_old + gp_new;
            bs_next = bs_reg - bp_old + bp_new;
            gt_next = gt_reg - GT_W'(o_gain) + GT_W'(ngain);
            ram_wdata = {nr, ng, nb, ngain};
        end
        else
        begin
            rs_next = rs_base + rp_new;
            gs_next = gs_base + gp_new;
            bs_next = bs_base + bp_new;
            gt_next = gt_base + GT_W'(ngain);
            ram_wdata = {nr, ng, nb, ngain};
        end
    end

    // store write and queue pop
    always_comb
    begin
        item_pop  = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = ptr_reg;
        case (state_reg)
            S_IDLE:
            begin
                item_pop = item_valid;
                if (item_valid && (fill_eff < FILL_W'(WINDOW)))
                begin
                    ram_we    = 1'b1;
                    ram_waddr = fill_eff[ADDR_W-1:0];
                end
            end
            S_READ:
            begin
                ram_we = 1'b1;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // quotient step compares for the three channels
    assign r_ge = CMP_W'(rr_reg) >= CMP_W'(dv_reg);
    assign g_ge = CMP_W'(gr_reg) >= CMP_W'(dv_reg);
    assign b_ge = CMP_W'(br_reg) >= CMP_W'(dv_reg);

    // sequencer and running state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
            ptr_reg   <= '0;
            rs_reg    <= '0;
            gs_reg    <= '0;
            bs_reg    <= '0;
            gt_reg    <= GT_W'(1);
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            // result register flag, a new result replaces one popped in the same cycle
            if (state_reg == S_OUT && out_free)
            begin
                ov_reg <= 1'b1;
            end
            else if (pop && ov_reg)
            begin
                ov_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (item_valid)
                    begin
                        if (fill_eff < FILL_W'(WINDOW))
                        begin
                            fill_reg <= fill_eff + FILL_W'(1);
                            ptr_reg  <= ptr_eff;
                            rs_reg   <= rs_next;
                            gs_reg   <= gs_next;
                            bs_reg   <= bs_next;
                            gt_reg   <= gt_next;
                        end
                        else
                        begin
                            state_reg <= S_READ;
                        end
                    end
                end
                S_READ:
                begin
                    rs_reg  <= rs_next;
                    gs_reg  <= gs_next;
                    bs_reg  <= bs_next;
                    gt_reg  <= gt_next;
                    ptr_reg <= (ptr_reg == ADDR_W'(WINDOW - 1)) ? '0 : ptr_reg + ADDR_W'(1);
                    cnt_reg <= 3'(QW - 1);
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (cnt_reg == '0)
                    begin
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 3'd1;
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // item latch, quotient datapath and result register
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && item_valid)
        begin
            cur_reg <= item;
        end
        if (state_reg == S_READ)
        begin
            rr_reg <= rs_next;
            gr_reg <= gs_next;
            br_reg <= bs_next;
            dv_reg <= {gt_next, (QW-1)'(0)};
            rq_reg <= '0;
            gq_reg <= '0;
            bq_reg <= '0;
        end
        else if (state_reg == S_DIV)
        begin
            if (r_ge) rr_reg <= rr_reg - SUM_W'(dv_reg);
            if (g_ge) gr_reg <= gr_reg - SUM_W'(dv_reg);
            if (b_ge) br_reg <= br_reg - SUM_W'(dv_reg);
            rq_reg <= {rq_reg[QW-2:0], r_ge};
            gq_reg <= {gq_reg[QW-2:0], g_ge};
            bq_reg <= {bq_reg[QW-2:0], b_ge};
            dv_reg <= dv_reg >> 1;
        end
        if (state_reg == S_OUT && out_free)
        begin
            ro_reg <= rq_reg;
            go_reg <= gq_reg;
            bo_reg <= bq_reg;
        end
    end
endmodule
`default_nettype wire
